// File: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants, register codes and the point record for the line engine.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS     = 12;
    localparam int ADDR_BITS      = 22;
    localparam int CFG_BITS       = 12;
    localparam int COLOR_BITS     = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam int DX_BITS  = COORD_BITS + 1;
    localparam int NDY_BITS = COORD_BITS + 2;
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int E2_BITS  = ERR_BITS + 1;
    localparam int CMP_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
    localparam int PROD_BITS = 2 * CFG_BITS;
    localparam int SUM_BITS  = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB_HEIGHT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLIP      = CFG_INDEX_BITS'(2);

    localparam logic [CFG_BITS-1:0] FB_WIDTH_RST  = CFG_BITS'(800);
    localparam logic [CFG_BITS-1:0] FB_HEIGHT_RST = CFG_BITS'(480);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic                         pt_valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic [COLOR_BITS-1:0]        color;
    } t_point;

endpackage

// File: design/lpr_step.sv
// ----------------------------------------------------------------------------
// lpr_step
// Line state and Bresenham error step; registers the point of each request.
// ----------------------------------------------------------------------------
module lpr_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic                                  i_adv,
    input  logic                                  i_op,
    input  logic signed [lpr_pkg::COORD_BITS-1:0] i_x_start,
    input  logic signed [lpr_pkg::COORD_BITS-1:0] i_y_start,
    input  logic signed [lpr_pkg::COORD_BITS-1:0] i_x_end,
    input  logic signed [lpr_pkg::COORD_BITS-1:0] i_y_end,
    input  logic [lpr_pkg::COLOR_BITS-1:0]        i_color,
    output logic                                  o_a_valid,
    output lpr_pkg::t_point                       o_point
);

    logic signed [lpr_pkg::COORD_BITS-1:0] r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic [lpr_pkg::DX_BITS-1:0]           r_abs_dx;
    logic signed [lpr_pkg::NDY_BITS-1:0]   r_neg_abs_dy;
    logic                                  r_step_x_neg, r_step_y_neg;
    logic signed [lpr_pkg::ERR_BITS-1:0]   r_err;
    logic [lpr_pkg::COLOR_BITS-1:0]        r_color;
    logic                                  r_busy;
    logic                                  r_a_valid;
    lpr_pkg::t_point                       r_point;

    logic                                  start;
    logic signed [lpr_pkg::DX_BITS-1:0]    dx, dy;
    logic [lpr_pkg::DX_BITS-1:0]           s_abs_dx;
    logic signed [lpr_pkg::NDY_BITS-1:0]   dy_w, s_nady;
    logic signed [lpr_pkg::ERR_BITS-1:0]   s_err;

    logic signed [lpr_pkg::COORD_BITS-1:0] e_x, e_y, e_ex, e_ey;
    logic [lpr_pkg::DX_BITS-1:0]           e_adx;
    logic signed [lpr_pkg::NDY_BITS-1:0]   e_nady;
    logic                                  e_sxn, e_syn, e_busy, e_last;
    logic signed [lpr_pkg::ERR_BITS-1:0]   e_err;
    logic [lpr_pkg::COLOR_BITS-1:0]        e_color;

    logic signed [lpr_pkg::E2_BITS-1:0]    e2, nady_w, adx_w, err_w, err_sum;
    logic                                  cond_x, cond_y;
    logic signed [lpr_pkg::COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic signed [lpr_pkg::ERR_BITS-1:0]   n_err;

    assign start = i_load && (i_op == lpr_pkg::OP_START);

    always_comb begin
        dx       = {i_x_end[lpr_pkg::COORD_BITS-1], i_x_end}
                 - {i_x_start[lpr_pkg::COORD_BITS-1], i_x_start};
        dy       = {i_y_end[lpr_pkg::COORD_BITS-1], i_y_end}
                 - {i_y_start[lpr_pkg::COORD_BITS-1], i_y_start};
        s_abs_dx = dx[lpr_pkg::DX_BITS-1] ? lpr_pkg::DX_BITS'(-dx) : dx;
        dy_w     = lpr_pkg::NDY_BITS'(dy);
        s_nady   = dy[lpr_pkg::DX_BITS-1] ? dy_w : -dy_w;
        s_err    = $signed({2'b00, s_abs_dx}) + lpr_pkg::ERR_BITS'(s_nady);
    end

    always_comb begin
        e_x     = start ? i_x_start : r_cur_x;
        e_y     = start ? i_y_start : r_cur_y;
        e_ex    = start ? i_x_end   : r_end_x;
        e_ey    = start ? i_y_end   : r_end_y;
        e_adx   = start ? s_abs_dx  : r_abs_dx;
        e_nady  = start ? s_nady    : r_neg_abs_dy;
        e_sxn   = start ? !(i_x_start < i_x_end) : r_step_x_neg;
        e_syn   = start ? !(i_y_start < i_y_end) : r_step_y_neg;
        e_err   = start ? s_err     : r_err;
        e_color = start ? i_color   : r_color;
        e_busy  = start || r_busy;
        e_last  = (e_x == e_ex) && (e_y == e_ey);
    end

    always_comb begin
        e2      = {e_err, 1'b0};
        nady_w  = lpr_pkg::E2_BITS'(e_nady);
        adx_w   = $signed(lpr_pkg::E2_BITS'(e_adx));
        err_w   = lpr_pkg::E2_BITS'(e_err);
        cond_x  = (e2 >= nady_w);
        cond_y  = (e2 <= adx_w);
        err_sum = err_w + (cond_x ? nady_w : '0) + (cond_y ? adx_w : '0);
        n_err   = e_err;
        n_cur_x = e_x;
        n_cur_y = e_y;
        if (e_busy && !e_last) begin
            n_err = err_sum[lpr_pkg::ERR_BITS-1:0];
            if (cond_x) begin
                n_cur_x = e_sxn ? e_x - lpr_pkg::COORD_BITS'(1)
                                : e_x + lpr_pkg::COORD_BITS'(1);
            end
            if (cond_y) begin
                n_cur_y = e_syn ? e_y - lpr_pkg::COORD_BITS'(1)
                                : e_y + lpr_pkg::COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= e_busy && !e_last;
            end
            if (i_adv) begin
                r_a_valid <= i_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_end_x      <= e_ex;
            r_end_y      <= e_ey;
            r_abs_dx     <= e_adx;
            r_neg_abs_dy <= e_nady;
            r_step_x_neg <= e_sxn;
            r_step_y_neg <= e_syn;
            r_err        <= n_err;
            r_color      <= e_color;
        end
        if (i_adv) begin
            r_point.pt_valid <= e_busy;
            r_point.x        <= e_x;
            r_point.y        <= e_y;
            r_point.last     <= e_busy && e_last;
            r_point.color    <= e_busy ? e_color : '0;
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_point   = r_point;

endmodule

// File: design/lpr_addr.sv
// ----------------------------------------------------------------------------
// lpr_addr
// Clips, flips and maps a point to a frame-buffer address; result register.
// ----------------------------------------------------------------------------
module lpr_addr (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_a_valid,
    input  lpr_pkg::t_point                      i_point,
    input  logic [lpr_pkg::CFG_BITS-1:0]         i_fb_width,
    input  logic [lpr_pkg::CFG_BITS-1:0]         i_fb_height,
    input  logic                                 i_flip,
    output logic                                 o_valid,
    output logic                                 o_point_valid,
    output logic                                 o_pixel_write,
    output logic [lpr_pkg::ADDR_BITS-1:0]        o_pixel_addr,
    output logic [lpr_pkg::COLOR_BITS-1:0]       o_pixel_color,
    output logic                                 o_last_point
);

    logic                                r_valid;
    logic                                r_point_valid, r_pixel_write, r_last_point;
    logic [lpr_pkg::ADDR_BITS-1:0]       r_pixel_addr;
    logic [lpr_pkg::COLOR_BITS-1:0]      r_pixel_color;

    logic [lpr_pkg::CMP_BITS-1:0]        x_w, y_w, w_w, h_w;
    logic                                in_frame;
    logic [lpr_pkg::CFG_BITS-1:0]        x_t, y_t, col, row;
    logic [lpr_pkg::SUM_BITS-1:0]        prod, sum;

    always_comb begin
        x_w      = lpr_pkg::CMP_BITS'($unsigned(i_point.x));
        y_w      = lpr_pkg::CMP_BITS'($unsigned(i_point.y));
        w_w      = lpr_pkg::CMP_BITS'(i_fb_width);
        h_w      = lpr_pkg::CMP_BITS'(i_fb_height);
        in_frame = !i_point.x[lpr_pkg::COORD_BITS-1] && !i_point.y[lpr_pkg::COORD_BITS-1]
                && (x_w < w_w) && (y_w < h_w);
        x_t      = x_w[lpr_pkg::CFG_BITS-1:0];
        y_t      = y_w[lpr_pkg::CFG_BITS-1:0];
        col      = i_flip ? i_fb_width  - lpr_pkg::CFG_BITS'(1) - x_t : x_t;
        row      = i_flip ? i_fb_height - lpr_pkg::CFG_BITS'(1) - y_t : y_t;
        prod     = lpr_pkg::SUM_BITS'(row) * lpr_pkg::SUM_BITS'(i_fb_width);
        sum      = prod + lpr_pkg::SUM_BITS'(col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_point_valid <= i_point.pt_valid;
            r_pixel_write <= i_point.pt_valid && in_frame;
            r_pixel_addr  <= (i_point.pt_valid && in_frame) ? sum[lpr_pkg::ADDR_BITS-1:0] : '0;
            r_pixel_color <= i_point.color;
            r_last_point  <= i_point.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_point_valid = r_point_valid;
    assign o_pixel_write = r_pixel_write;
    assign o_pixel_addr  = r_pixel_addr;
    assign o_pixel_color = r_pixel_color;
    assign o_last_point  = r_last_point;

endmodule

// File: design/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line engine: one clipped, optionally flipped pixel per request.
//
//   channel | direction | handshake               | payload
//   in      | sink      | i_in_valid / o_in_ready | op, endpoints, colour
//   out     | source    | o_out_valid/i_out_ready | point, write, addr, colour, last
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | register index, data
//
// One request per cycle unless back-pressured. Each request passes the step
// stage, then the address stage with the multiply-add; the error step and
// line state update are combinational. Reset empties both stages and ends
// any line. A stalled output holds the result and back-pressures the input
// only once both stages are full. Config writes are always taken.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic                                      i_op,
    input  logic signed [lpr_pkg::COORD_BITS-1:0]     i_x_start,
    input  logic signed [lpr_pkg::COORD_BITS-1:0]     i_y_start,
    input  logic signed [lpr_pkg::COORD_BITS-1:0]     i_x_end,
    input  logic signed [lpr_pkg::COORD_BITS-1:0]     i_y_end,
    input  logic [lpr_pkg::COLOR_BITS-1:0]            i_color,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic                                      o_point_valid,
    output logic                                      o_pixel_write,
    output logic [lpr_pkg::ADDR_BITS-1:0]             o_pixel_addr,
    output logic [lpr_pkg::COLOR_BITS-1:0]            o_pixel_color,
    output logic                                      o_last_point,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [lpr_pkg::CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [lpr_pkg::CFG_BITS-1:0]              i_cfg_data
);

    logic [lpr_pkg::CFG_BITS-1:0] r_fb_width, r_fb_height;
    logic                         r_flip;

    logic            a_valid, adv_a, adv_b, in_acc, cfg_acc;
    lpr_pkg::t_point a_point;

    assign adv_b       = !o_out_valid || i_out_ready;
    assign adv_a       = !a_valid || adv_b;
    assign o_in_ready  = adv_a;
    assign in_acc      = i_in_valid && adv_a;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= lpr_pkg::FB_WIDTH_RST;
            r_fb_height <= lpr_pkg::FB_HEIGHT_RST;
            r_flip      <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                lpr_pkg::CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                lpr_pkg::CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                lpr_pkg::CFG_FLIP:      r_flip      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lpr_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_acc),
        .i_adv     (adv_a),
        .i_op      (i_op),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .i_color   (i_color),
        .o_a_valid (a_valid),
        .o_point   (a_point)
    );

    lpr_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv_b),
        .i_a_valid     (a_valid),
        .i_point       (a_point),
        .i_fb_width    (r_fb_width),
        .i_fb_height   (r_fb_height),
        .i_flip        (r_flip),
        .o_valid       (o_out_valid),
        .o_point_valid (o_point_valid),
        .o_pixel_write (o_pixel_write),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_color (o_pixel_color),
        .o_last_point  (o_last_point)
    );

    a_write_needs_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pixel_write |-> o_point_valid)
        else $error("pixel write without a line point");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_point_valid |->
            !o_pixel_write && !o_last_point && (o_pixel_addr == '0) && (o_pixel_color == '0))
        else $error("inactive result carries data");

    a_clipped_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_write |-> (o_pixel_addr == '0))
        else $error("clipped point with non-zero address");

    a_stage_a_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> a_valid)
        else $error("accepted request lost before result stage");

endmodule

// File: tb/sv/line_pixel_rasterizer_test.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_test
// Self-checking bench for the Bresenham line engine. Requests and results run
// over valid/ready with random gaps and stalls on both sides. A behavioural
// line tracer predicts every point, clip decision and frame address; results
// are checked in order, field by field. Frame size and flip are reprogrammed
// between phases, extremes included.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lpr_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE =
        lpr_pkg::CFG_INDEX_BITS'(3);

    typedef struct packed {
        logic                           point_valid;
        logic                           pixel_write;
        logic [lpr_pkg::ADDR_BITS-1:0]  pixel_addr;
        logic [lpr_pkg::COLOR_BITS-1:0] pixel_color;
        logic                           last_point;
    } t_pixel;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    logic                                   i_op;
    logic signed [lpr_pkg::COORD_BITS-1:0]  i_x_start;
    logic signed [lpr_pkg::COORD_BITS-1:0]  i_y_start;
    logic signed [lpr_pkg::COORD_BITS-1:0]  i_x_end;
    logic signed [lpr_pkg::COORD_BITS-1:0]  i_y_end;
    logic [lpr_pkg::COLOR_BITS-1:0]         i_color;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    logic                                   o_point_valid;
    logic                                   o_pixel_write;
    logic [lpr_pkg::ADDR_BITS-1:0]          o_pixel_addr;
    logic [lpr_pkg::COLOR_BITS-1:0]         o_pixel_color;
    logic                                   o_last_point;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [lpr_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [lpr_pkg::CFG_BITS-1:0]           i_cfg_data;

    line_pixel_rasterizer dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // frame settings and line tracer state
    int   fb_w = 800;
    int   fb_h = 480;
    bit   fb_flip = 1'b0;
    int   ln_x, ln_y, ln_end_x, ln_end_y;
    int   ln_adx, ln_nady, ln_err;
    bit   ln_xneg, ln_yneg, ln_active;
    logic [lpr_pkg::COLOR_BITS-1:0] ln_color;

    t_pixel pixel_queue[$];
    int     error_count = 0;
    int     requests_sent = 0;
    int     results_checked = 0;
    int     settings_used = 0;
    bit     no_gaps = 1'b0;

    task automatic report(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    function automatic int rand_coord();
        logic signed [lpr_pkg::COORD_BITS-1:0] v;
        v = lpr_pkg::COORD_BITS'($urandom);
        return v;
    endfunction

    // mostly around the frame, with edges, wild values and the extremes
    function automatic int pick_coord(int span);
        int lim;
        lim = (span > 2044) ? 2044 : span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(0, lim + 6)) - 3;
            6, 7:             return rand_coord();
            8:                return $urandom_range(0, 1) ? -2048 : 2047;
            default:          return clamp_coord(span - 2 + int'($urandom_range(0, 2)));
        endcase
    endfunction

    function automatic t_pixel step_line(logic op,
                                         logic signed [lpr_pkg::COORD_BITS-1:0] xs,
                                         logic signed [lpr_pkg::COORD_BITS-1:0] ys,
                                         logic signed [lpr_pkg::COORD_BITS-1:0] xe,
                                         logic signed [lpr_pkg::COORD_BITS-1:0] ye,
                                         logic [lpr_pkg::COLOR_BITS-1:0] col);
        t_pixel px;
        int     dx, dy, e2;
        longint row, column;
        px = '0;
        if (op == lpr_pkg::OP_START) begin
            ln_x     = xs;
            ln_y     = ys;
            ln_end_x = xe;
            ln_end_y = ye;
            dx       = ln_end_x - ln_x;
            dy       = ln_end_y - ln_y;
            ln_adx   = (dx < 0) ? -dx : dx;
            ln_nady  = (dy < 0) ? dy : -dy;
            ln_xneg  = !(ln_x < ln_end_x);
            ln_yneg  = !(ln_y < ln_end_y);
            ln_err   = ln_adx + ln_nady;
            ln_color = col;
            ln_active = 1'b1;
        end
        if (!ln_active)
            return px;
        px.point_valid = 1'b1;
        px.pixel_color = ln_color;
        px.last_point  = (ln_x == ln_end_x) && (ln_y == ln_end_y);
        if (ln_x >= 0 && ln_y >= 0 && ln_x < fb_w && ln_y < fb_h) begin
            px.pixel_write = 1'b1;
            column = ln_x;
            row    = ln_y;
            if (fb_flip) begin
                column = fb_w - 1 - column;
                row    = fb_h - 1 - row;
            end
            px.pixel_addr = lpr_pkg::ADDR_BITS'(row * fb_w + column);
        end
        if (px.last_point) begin
            ln_active = 1'b0;
        end else begin
            e2 = 2 * ln_err;
            if (e2 >= ln_nady) begin
                ln_err += ln_nady;
                ln_x   += ln_xneg ? -1 : 1;
            end
            if (e2 <= ln_adx) begin
                ln_err += ln_adx;
                ln_y   += ln_yneg ? -1 : 1;
            end
        end
        return px;
    endfunction

    // called on a rising edge; valid stays up for a back-to-back request
    task automatic send_request(logic op, int xs, int ys, int xe, int ye,
                                logic [lpr_pkg::COLOR_BITS-1:0] col);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_x_start  <= lpr_pkg::COORD_BITS'(xs);
        i_y_start  <= lpr_pkg::COORD_BITS'(ys);
        i_x_end    <= lpr_pkg::COORD_BITS'(xe);
        i_y_end    <= lpr_pkg::COORD_BITS'(ye);
        i_color    <= col;
        do @(posedge i_clk); while (!o_in_ready);
        pixel_queue.push_back(step_line(op, lpr_pkg::COORD_BITS'(xs),
                                        lpr_pkg::COORD_BITS'(ys),
                                        lpr_pkg::COORD_BITS'(xe),
                                        lpr_pkg::COORD_BITS'(ye), col));
        requests_sent++;
    endtask

    task automatic draw_line(int xs, int ys, int xe, int ye,
                             logic [lpr_pkg::COLOR_BITS-1:0] col, int steps);
        send_request(lpr_pkg::OP_START, xs, ys, xe, ye, col);
        repeat (steps)
            send_request(lpr_pkg::OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), lpr_pkg::COLOR_BITS'($urandom));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lpr_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [lpr_pkg::CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_frame(int w, int h, bit f);
        wait_idle();
        write_reg(lpr_pkg::CFG_FB_WIDTH, lpr_pkg::CFG_BITS'(w));
        fb_w = w;
        write_reg(lpr_pkg::CFG_FB_HEIGHT, lpr_pkg::CFG_BITS'(h));
        fb_h = h;
        // only bit 0 of the flip register counts
        write_reg(lpr_pkg::CFG_FLIP, {(lpr_pkg::CFG_BITS-1)'($urandom), f});
        fb_flip = f;
        write_reg(CFG_SPARE, lpr_pkg::CFG_BITS'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_lines(int count);
        int stop, xs, ys, xe, ye, reach, dxa, dya, len, steps;
        stop = requests_sent + count;
        while (requests_sent < stop) begin
            if ($urandom_range(0, 19) == 0) begin
                send_request(lpr_pkg::OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), lpr_pkg::COLOR_BITS'($urandom));
            end else begin
                reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
                xs  = pick_coord(fb_w);
                ys  = pick_coord(fb_h);
                xe  = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
                ye  = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
                dxa = (xe > xs) ? xe - xs : xs - xe;
                dya = (ye > ys) ? ye - ys : ys - ye;
                len = (dxa > dya) ? dxa : dya;
                case ($urandom_range(0, 9))
                    0:       steps = $urandom_range(0, len);
                    1:       steps = len + $urandom_range(1, 3);
                    default: steps = len;
                endcase
                draw_line(xs, ys, xe, ye, lpr_pkg::COLOR_BITS'($urandom), steps);
            end
        end
    endtask

    task automatic test_idle_after_reset();
        repeat (2)
            send_request(lpr_pkg::OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), lpr_pkg::COLOR_BITS'($urandom));
    endtask

    task automatic test_directed_lines();
        draw_line(0, 0, 0, 0, 16'hFFFF, 1);
        draw_line(-2048, -2048, -2048, -2048, 16'h0000, 0);
        draw_line(2047, 2047, 2047, 2047, 16'h0001, 0);
        draw_line(799, 479, 801, 477, 16'h5A5A, 2);
        draw_line(3, 0, 0, 2, 16'hF800, 3);
        // long diagonal dropped after one step
        draw_line(-2048, 2047, 2047, -2048, 16'hA5A5, 1);
        draw_line(10, 10, 20, 20, 16'h07E0, 1);
        draw_line(5, 5, 5, 3, 16'h001F, 2);
        draw_line(-1, -1, 1, 0, 16'h8410, 2);
    endtask

    task automatic test_frame_settings();
        int w_list[9] = '{800, 800, 1, 1, 0, 640, 4095, 4095, 2048};
        int h_list[9] = '{480, 480, 1, 1, 480, 0, 4095, 4095, 2048};
        bit f_list[9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int i = 0; i < 11; i++) begin
            if (i < 9)
                set_frame(w_list[i], h_list[i], f_list[i]);
            else
                set_frame($urandom_range(1, 4095), $urandom_range(1, 4095),
                          1'($urandom_range(0, 1)));
            run_lines(160);
        end
    endtask

    task automatic test_back_to_back();
        set_frame(320, 240, 1'b0);
        no_gaps = 1'b1;
        run_lines(150);
        no_gaps = 1'b0;
    endtask

    // sender holds off until the pipe is empty, possibly in the middle of a line
    task automatic test_pause_and_resume();
        repeat (3) begin
            run_lines(20);
            wait_idle();
        end
    endtask

    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_queue.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                want = pixel_queue.pop_front();
                check_field("point_valid", 32'(o_point_valid), 32'(want.point_valid));
                check_field("pixel_write", 32'(o_pixel_write), 32'(want.pixel_write));
                check_field("pixel_addr", 32'(o_pixel_addr), 32'(want.pixel_addr));
                check_field("pixel_color", 32'(o_pixel_color), 32'(want.pixel_color));
                check_field("last_point", 32'(o_last_point), 32'(want.last_point));
                results_checked++;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", pixel_queue.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= lpr_pkg::OP_ADVANCE;
        i_x_start   <= '0;
        i_y_start   <= '0;
        i_x_end     <= '0;
        i_y_end     <= '0;
        i_color     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= lpr_pkg::CFG_FB_WIDTH;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_directed_lines();
        test_frame_settings();
        test_back_to_back();
        test_pause_and_resume();

        i_in_valid <= 1'b0;
        for (int n = 0; n < 2000 && pixel_queue.size() != 0; n++)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (pixel_queue.size() != 0)
            report($sformatf("%0d results never arrived", pixel_queue.size()));
        $display("Drove %0d requests and checked %0d results", requests_sent,
                 results_checked);
        $display("across %0d frame settings, with and without flip", settings_used);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
design/lpr_pkg.sv
design/lpr_step.sv
design/lpr_addr.sv
design/line_pixel_rasterizer.sv
tb/sv/line_pixel_rasterizer_test.sv
